/* src/tccs_pkg.sv */
// ----------------------------------------------------------------------------
// tccs_pkg
// Types, constants and helper functions shared by the text console engine.
// ----------------------------------------------------------------------------
package tccs_pkg;

  // Screen geometry
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int CNT_W      = $clog2(CELLS + 1);

  // Stream word layouts
  localparam int IN_FIELDS_W  = CHAR_W + COL_W + ROW_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_USER_W    = 8;
  localparam int OUT_FIELDS_W = COL_W + ROW_W + CELL_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_COLOR_ATTRIBUTE = 1'b0;  // word index, paddr[2]

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL       = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

  // Command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Tab stops that a column below 2**COL_W can reach
  localparam int TAB_COUNT = (1 << COL_W) / TAB_STOP + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_PRINT   = 4'd1,
    OP_NEWLINE = 4'd2,
    OP_TAB     = 4'd3,
    OP_CR      = 4'd4,
    OP_BS      = 4'd5,
    OP_SETCUR  = 4'd6,
    OP_CLEAR   = 4'd7,
    OP_READ    = 4'd8
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
  } entry_t;

  typedef struct packed {
    logic init_busy;
  } status_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS));
    return ADDR_W'(base + ADDR_W'(col));
  endfunction

  // Smallest multiple of the tab stop above the column.
  function automatic logic [COL_W:0] next_tab(input logic [COL_W-1:0] col);
    logic [COL_W:0] res;
    logic [COL_W:0] stop;
    res = '0;
    for (int k = TAB_COUNT; k >= 1; k--) begin
      stop = (COL_W + 1)'(k * TAB_STOP);
      if (stop > {1'b0, col}) res = stop;
    end
    return res;
  endfunction

endpackage

/* src/text_console_cursor_scroll.sv */
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text-mode console engine: character cell store, cursor and terminal rules.
// ----------------------------------------------------------------------------
// Each input word is one command and gives one result word. Put character,
// set cursor and ignored commands pass through the command queue and the
// back end's result register, and read cell also waits for the store's read
// data, which is registered. Clear screen and any put character
// that scrolls walk the whole 2000-cell store through its one read and one
// write port, one cell a cycle, before the result appears; other words queue
// up behind them. After reset the store is blanked by the same walk, during
// which s_axis_tready stays low; configuration writes are taken throughout.
module text_console_cursor_scroll (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Command stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: char_code [7:0], column [14:8], row [19:15], zero above
  input  logic [tccs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: command [1:0], zero above
  input  logic [tccs_pkg::IN_USER_W-1:0]  s_axis_tuser,
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: cursor_column [6:0], cursor_row [11:7], cell_word [27:12],
  //        scrolled [28], zero above
  output logic [tccs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tccs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tccs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tccs_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic [tccs_pkg::ATTR_W-1:0] attr_q;
  logic                        reg_hit;
  tccs_pkg::status_t           status;
  tccs_pkg::entry_t            push_entry, pop_entry;
  logic                        push, pop, full, empty;

  // Byte address bits below the word are not decoded.
  assign reg_hit = (paddr[2] == tccs_pkg::REG_COLOR_ATTRIBUTE);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? tccs_pkg::APB_DATA_W'(attr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tccs_pkg::ATTR_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      attr_q <= pwdata[tccs_pkg::ATTR_W-1:0];
    end
  end

  tccs_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .status_i      (status),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  tccs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .empty_o (empty)
  );

  tccs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (pop_entry),
    .empty_i       (empty),
    .pop_o         (pop),
    .attr_i        (attr_q),
    .status_o      (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* src/tccs_front.sv */
// ----------------------------------------------------------------------------
// tccs_front
// Accepts command words and sorts them into the operations the back end runs.
// ----------------------------------------------------------------------------
module tccs_front (
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tccs_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic [tccs_pkg::IN_USER_W-1:0] s_axis_tuser,
  input  tccs_pkg::status_t              status_i,
  input  logic                           full_i,
  output logic                           push_o,
  output tccs_pkg::entry_t               entry_o
);

  tccs_pkg::cmd_e                  cmd;
  logic [tccs_pkg::CHAR_W-1:0]     char_code;
  logic [tccs_pkg::COL_W-1:0]      column;
  logic [tccs_pkg::ROW_W-1:0]      row;
  logic                            in_screen;
  tccs_pkg::op_e                   op;

  assign cmd       = tccs_pkg::cmd_e'(s_axis_tuser[tccs_pkg::CMD_W-1:0]);
  assign char_code = s_axis_tdata[tccs_pkg::CHAR_W-1:0];
  assign column    = s_axis_tdata[tccs_pkg::CHAR_W +: tccs_pkg::COL_W];
  assign row       = s_axis_tdata[tccs_pkg::CHAR_W + tccs_pkg::COL_W +: tccs_pkg::ROW_W];

  assign in_screen = ({1'b0, column} < (tccs_pkg::COL_W + 1)'(tccs_pkg::COLUMNS)) &&
                     ({1'b0, row} < (tccs_pkg::ROW_W + 1)'(tccs_pkg::ROWS));

  always_comb begin
    op = tccs_pkg::OP_NOP;
    case (cmd)
      tccs_pkg::CMD_PUT: begin
        case (char_code)
          tccs_pkg::CH_NL:  op = tccs_pkg::OP_NEWLINE;
          tccs_pkg::CH_TAB: op = tccs_pkg::OP_TAB;
          tccs_pkg::CH_CR:  op = tccs_pkg::OP_CR;
          tccs_pkg::CH_BS:  op = tccs_pkg::OP_BS;
          default: begin
            // Bytes above 0x7F behave as negative chars and are dropped.
            if (char_code inside {[tccs_pkg::CH_PRINT_LO:tccs_pkg::CH_PRINT_HI]}) begin
              op = tccs_pkg::OP_PRINT;
            end
          end
        endcase
      end
      tccs_pkg::CMD_SET:   op = in_screen ? tccs_pkg::OP_SETCUR : tccs_pkg::OP_NOP;
      tccs_pkg::CMD_CLEAR: op = tccs_pkg::OP_CLEAR;
      tccs_pkg::CMD_READ:  op = in_screen ? tccs_pkg::OP_READ : tccs_pkg::OP_NOP;
      default:             op = tccs_pkg::OP_NOP;
    endcase
  end

  assign s_axis_tready     = !full_i && !status_i.init_busy;
  assign push_o            = s_axis_tvalid && s_axis_tready;
  assign entry_o.op        = op;
  assign entry_o.char_code = char_code;
  assign entry_o.column    = column;
  assign entry_o.row       = row;

endmodule

/* src/tccs_fifo.sv */
// ----------------------------------------------------------------------------
// tccs_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tccs_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tccs_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output tccs_pkg::entry_t entry_o,
  output logic             empty_o
);

  tccs_pkg::entry_t             entries_q [tccs_pkg::QUEUE_DEPTH];
  logic [tccs_pkg::QPTR_W-1:0]  wptr_q, wptr_d;
  logic [tccs_pkg::QPTR_W-1:0]  rptr_q, rptr_d;
  logic [tccs_pkg::QCNT_W-1:0]  count_q, count_d;

  localparam logic [tccs_pkg::QPTR_W-1:0] LastPtr = tccs_pkg::QPTR_W'(tccs_pkg::QUEUE_DEPTH - 1);

  assign full_o  = (count_q == tccs_pkg::QCNT_W'(tccs_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = entries_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wptr_q] <= entry_i;
    end
  end

endmodule

/* src/tccs_back.sv */
// ----------------------------------------------------------------------------
// tccs_back
// Runs queued operations against the cell store and the cursor, walks the
// store for clear, scroll and the blanking pass after reset, and holds the
// result word.
// ----------------------------------------------------------------------------
module tccs_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tccs_pkg::entry_t                entry_i,
  input  logic                            empty_i,
  output logic                            pop_o,
  input  logic [tccs_pkg::ATTR_W-1:0]     attr_i,
  output tccs_pkg::status_t               status_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tccs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_WALK = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    WK_INIT   = 2'd0,
    WK_CLEAR  = 2'd1,
    WK_SCROLL = 2'd2
  } walk_e;

  localparam int ColNW = tccs_pkg::COL_W + 1;
  localparam int RowNW = tccs_pkg::ROW_W + 1;

  state_e                          state_q, state_d;
  walk_e                           kind_q, kind_d;
  logic [tccs_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                            pend_q, pend_d;
  logic [tccs_pkg::ADDR_W-1:0]     wr_addr_q, wr_addr_d;
  logic                            wr_blank_q, wr_blank_d;
  logic [tccs_pkg::COL_W-1:0]      cur_col_q, cur_col_d;
  logic [tccs_pkg::ROW_W-1:0]      cur_row_q, cur_row_d;
  logic                            out_valid_q, out_valid_d;
  logic [tccs_pkg::COL_W-1:0]      out_col_q, out_col_d;
  logic [tccs_pkg::ROW_W-1:0]      out_row_q, out_row_d;
  logic [tccs_pkg::CELL_W-1:0]     out_word_q, out_word_d;
  logic                            out_scr_q, out_scr_d;

  logic [tccs_pkg::CELL_W-1:0]     mem_q [tccs_pkg::CELLS];
  logic [tccs_pkg::CELL_W-1:0]     rdata_q;
  logic                            mem_we, mem_re;
  logic [tccs_pkg::ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [tccs_pkg::CELL_W-1:0]     mem_wdata;

  logic                            out_free, pop, load_out, scroll, copy;
  logic [ColNW-1:0]                col_n;
  logic [RowNW-1:0]                row_n;
  logic [tccs_pkg::CNT_W-1:0]      src_idx;

  assign out_free = !out_valid_q || m_axis_tready;
  assign pop      = (state_q == ST_IDLE) && !empty_i && out_free;
  assign src_idx  = cnt_q + tccs_pkg::CNT_W'(tccs_pkg::COLUMNS);

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    wr_addr_d  = wr_addr_q;
    wr_blank_d = wr_blank_q;
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_word_d = out_word_q;
    out_scr_d  = out_scr_q;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    scroll     = 1'b0;
    copy       = 1'b0;
    col_n      = {1'b0, cur_col_q};
    row_n      = {1'b0, cur_row_q};

    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          case (entry_i.op)
            tccs_pkg::OP_PRINT: begin
              mem_we    = 1'b1;
              mem_waddr = tccs_pkg::cell_addr(cur_row_q, cur_col_q);
              mem_wdata = {attr_i, entry_i.char_code};
              col_n     = col_n + 1'b1;
            end
            tccs_pkg::OP_NEWLINE: begin
              col_n = '0;
              row_n = row_n + 1'b1;
            end
            tccs_pkg::OP_TAB:    col_n = tccs_pkg::next_tab(cur_col_q);
            tccs_pkg::OP_CR:     col_n = '0;
            tccs_pkg::OP_BS: begin
              if (cur_col_q != '0) col_n = col_n - 1'b1;
            end
            tccs_pkg::OP_SETCUR: begin
              col_n = {1'b0, entry_i.column};
              row_n = {1'b0, entry_i.row};
            end
            tccs_pkg::OP_CLEAR: begin
              col_n = '0;
              row_n = '0;
            end
            tccs_pkg::OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = tccs_pkg::cell_addr(entry_i.row, entry_i.column);
            end
            default: ;
          endcase

          if (col_n >= ColNW'(tccs_pkg::COLUMNS)) begin
            col_n = '0;
            row_n = row_n + 1'b1;
          end
          scroll = (row_n >= RowNW'(tccs_pkg::ROWS));
          if (scroll) row_n = RowNW'(tccs_pkg::ROWS - 1);
          cur_col_d = col_n[tccs_pkg::COL_W-1:0];
          cur_row_d = row_n[tccs_pkg::ROW_W-1:0];

          if (entry_i.op == tccs_pkg::OP_CLEAR) begin
            state_d = ST_WALK;
            kind_d  = WK_CLEAR;
            cnt_d   = '0;
          end else if (scroll) begin
            state_d = ST_WALK;
            kind_d  = WK_SCROLL;
            cnt_d   = '0;
          end else if (entry_i.op == tccs_pkg::OP_READ) begin
            state_d = ST_READ;
          end else begin
            load_out   = 1'b1;
            out_col_d  = cur_col_d;
            out_row_d  = cur_row_d;
            out_word_d = '0;
            out_scr_d  = 1'b0;
          end
        end
      end

      ST_READ: begin
        load_out   = 1'b1;
        out_col_d  = cur_col_q;
        out_row_d  = cur_row_q;
        out_word_d = rdata_q;
        out_scr_d  = 1'b0;
        state_d    = ST_IDLE;
      end

      ST_WALK: begin
        // Each cell is written on the cycle following its visit, so a copied
        // word has its read data in hand when the write lands.
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_q;
          mem_wdata = wr_blank_q ? tccs_pkg::BLANK_CELL : rdata_q;
        end
        if (cnt_q != tccs_pkg::CNT_W'(tccs_pkg::CELLS)) begin
          copy       = (kind_q == WK_SCROLL) &&
                       (cnt_q < tccs_pkg::CNT_W'(tccs_pkg::COPY_CELLS));
          pend_d     = 1'b1;
          wr_addr_d  = cnt_q[tccs_pkg::ADDR_W-1:0];
          wr_blank_d = !copy;
          cnt_d      = cnt_q + 1'b1;
          if (copy) begin
            mem_re    = 1'b1;
            mem_raddr = src_idx[tccs_pkg::ADDR_W-1:0];
          end
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = ST_IDLE;
            if (kind_q != WK_INIT) begin
              load_out   = 1'b1;
              out_col_d  = cur_col_q;
              out_row_d  = cur_row_q;
              out_word_d = '0;
              out_scr_d  = (kind_q == WK_SCROLL);
            end
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WALK;
      kind_q      <= WK_INIT;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q  <= wr_addr_d;
    wr_blank_q <= wr_blank_d;
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
    out_word_q <= out_word_d;
    out_scr_q  <= out_scr_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign pop_o              = pop;
  assign status_o.init_busy = (state_q == ST_WALK) && (kind_q == WK_INIT);
  assign m_axis_tvalid      = out_valid_q;
  assign m_axis_tdata       = {{(tccs_pkg::OUT_DATA_W - tccs_pkg::OUT_FIELDS_W){1'b0}},
                               out_scr_q, out_word_q, out_row_q, out_col_q};

  a_pend_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q == ST_WALK)
    else $error("delayed store write outside a walk");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_col_q} < ColNW'(tccs_pkg::COLUMNS)) &&
    ({1'b0, cur_row_q} < RowNW'(tccs_pkg::ROWS)))
    else $error("cursor left the screen");

  a_read_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> !out_valid_q)
    else $error("read result would overwrite a waiting word");

  a_walk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tccs_pkg::CNT_W'(tccs_pkg::CELLS))
    else $error("walk counter ran past the store");

endmodule
